@@ rtl/core/xmr_pkg.sv @@
// xmodem receiver package: protocol codes, phase and status enums, per-item
// control state and result record shared by the step logic and the top level
// no dependencies
`timescale 1ns / 1ps

package xmr_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int IDX_BITS    = 7;
  localparam int TICK_BITS   = 21;
  localparam int SIZE_BITS   = 17;
  localparam int WADDR_BITS  = 16;

  localparam logic [IDX_BITS-1:0]  IDX_LAST      = IDX_BITS'(BLOCK_BYTES - 1);
  localparam logic [TICK_BITS-1:0] NAK_INTERVAL_RST = TICK_BITS'(2000000);

  localparam logic [7:0] C_SOH  = 8'h01;
  localparam logic [7:0] C_EOT  = 8'h04;
  localparam logic [7:0] C_ACK  = 8'h06;
  localparam logic [7:0] C_NAK  = 8'h15;
  localparam logic [7:0] C_CAN  = 8'h18;
  localparam logic [7:0] C_COMP = 8'hff;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CTRL,
    PH_NUM,
    PH_COMP,
    PH_DATA,
    PH_SUM
  } xmr_phase_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BYTE  = 2'd1,
    OP_START = 2'd2
  } xmr_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CANCEL   = 2'd1,
    ST_PROTO    = 2'd2,
    ST_OVERFLOW = 2'd3
  } xmr_status_e;

  typedef struct packed {
    xmr_phase_e           phase;
    logic                 started;
    logic [7:0]           expected;
    logic [7:0]           header;
    logic [IDX_BITS-1:0]  idx;
    logic [7:0]           sum;
    logic                 header_bad;
    logic [TICK_BITS-1:0] idle;
  } xmr_ctl_t;

  typedef struct packed {
    logic                  send_valid;
    logic [7:0]            send_byte;
    logic                  write_valid;
    logic [WADDR_BITS-1:0] write_address;
    logic [7:0]            write_data;
    logic                  finished;
    xmr_status_e           status;
    logic [SIZE_BITS-1:0]  total_size;
  } xmr_result_t;

endpackage

@@ rtl/core/xmr_step.sv @@
// xmodem receiver step logic: next control state and result for one item
// depends on xmr_pkg
`timescale 1ns / 1ps

module xmr_step import xmr_pkg::*; #(
  parameter int ADDR_BITS = 16
) (
  input  xmr_ctl_t             ctl_i,
  input  logic [ADDR_BITS:0]   acc_i,
  input  xmr_op_e              op_i,
  input  logic [7:0]           byte_i,
  input  logic [TICK_BITS-1:0] nak_interval_i,
  output xmr_ctl_t             ctl_o,
  output logic [ADDR_BITS:0]   acc_o,
  output xmr_result_t          res_o
);

  localparam int ExtW = ADDR_BITS + 18;
  localparam int CapW = ADDR_BITS + 2;

  logic [TICK_BITS-1:0] idle_inc;
  logic                 tick_nak;
  logic [CapW-1:0]      blk_end;
  logic                 overflow;
  logic                 sum_ok;
  logic [ExtW-1:0]      addr_ext;
  logic [ExtW-1:0]      size_ext;

  assign idle_inc = ctl_i.idle + TICK_BITS'(1);
  assign tick_nak = (ctl_i.phase == PH_CTRL) && !ctl_i.started && (idle_inc >= nak_interval_i);
  assign blk_end  = CapW'(acc_i) + CapW'(BLOCK_BYTES);
  assign overflow = blk_end > (CapW'(1) << ADDR_BITS);
  assign sum_ok   = !ctl_i.header_bad && (ctl_i.sum == byte_i);
  assign addr_ext = ExtW'(acc_i) + ExtW'(ctl_i.idx);
  assign size_ext = ExtW'(acc_o);

  // next state
  always_comb begin
    ctl_o = ctl_i;
    acc_o = acc_i;
    case (op_i)
      OP_START: begin
        ctl_o.phase      = PH_CTRL;
        ctl_o.started    = 1'b0;
        ctl_o.expected   = 8'd1;
        ctl_o.header     = 8'd0;
        ctl_o.idx        = '0;
        ctl_o.sum        = 8'd0;
        ctl_o.header_bad = 1'b0;
        ctl_o.idle       = '0;
        acc_o            = '0;
      end
      OP_TICK: begin
        if (ctl_i.phase == PH_CTRL && !ctl_i.started) begin
          ctl_o.idle = tick_nak ? '0 : idle_inc;
        end
      end
      OP_BYTE: begin
        unique case (ctl_i.phase)
          PH_CTRL: begin
            ctl_o.idle = '0;
            if (byte_i == C_EOT || byte_i == C_CAN) begin
              ctl_o.phase = PH_IDLE;
            end else if (byte_i == C_SOH) begin
              ctl_o.started = 1'b1;
              ctl_o.phase   = overflow ? PH_IDLE : PH_NUM;
            end else if (ctl_i.started) begin
              ctl_o.phase = PH_IDLE;
            end
          end
          PH_NUM: begin
            ctl_o.header     = byte_i;
            ctl_o.header_bad = (byte_i != ctl_i.expected);
            ctl_o.phase      = PH_COMP;
          end
          PH_COMP: begin
            if ((ctl_i.header ^ byte_i) != C_COMP) begin
              ctl_o.header_bad = 1'b1;
            end
            ctl_o.idx   = '0;
            ctl_o.sum   = 8'd0;
            ctl_o.phase = PH_DATA;
          end
          PH_DATA: begin
            ctl_o.sum = ctl_i.sum + byte_i;
            if (ctl_i.idx == IDX_LAST) begin
              ctl_o.idx   = '0;
              ctl_o.phase = PH_SUM;
            end else begin
              ctl_o.idx = ctl_i.idx + IDX_BITS'(1);
            end
          end
          PH_SUM: begin
            if (sum_ok) begin
              ctl_o.expected = ctl_i.expected + 8'd1;
              acc_o          = acc_i + (ADDR_BITS+1)'(BLOCK_BYTES);
            end
            ctl_o.phase = PH_CTRL;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // result of this item
  always_comb begin
    res_o               = '0;
    res_o.status        = ST_OK;
    res_o.total_size    = size_ext[SIZE_BITS-1:0];
    case (op_i)
      OP_TICK: begin
        if (tick_nak) begin
          res_o.send_valid = 1'b1;
          res_o.send_byte  = C_NAK;
        end
      end
      OP_BYTE: begin
        unique case (ctl_i.phase)
          PH_CTRL: begin
            if (byte_i == C_EOT) begin
              res_o.send_valid = 1'b1;
              res_o.send_byte  = C_ACK;
              res_o.finished   = 1'b1;
            end else if (byte_i == C_CAN) begin
              res_o.finished = 1'b1;
              res_o.status   = ST_CANCEL;
            end else if (byte_i == C_SOH) begin
              if (overflow) begin
                res_o.finished = 1'b1;
                res_o.status   = ST_OVERFLOW;
              end
            end else if (ctl_i.started) begin
              res_o.finished = 1'b1;
              res_o.status   = ST_PROTO;
            end
          end
          PH_DATA: begin
            if (!ctl_i.header_bad) begin
              res_o.write_valid   = 1'b1;
              res_o.write_address = addr_ext[WADDR_BITS-1:0];
              res_o.write_data    = byte_i;
            end
          end
          PH_SUM: begin
            res_o.send_valid = 1'b1;
            res_o.send_byte  = sum_ok ? C_ACK : C_NAK;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/xmodem_receiver.sv @@
// channel   dir  width   contents
// s_axis    in   8+2     rx byte in tdata, op in tuser
// m_axis    out  56+2+1  reply, buffer write, status and total size; session end on tlast
// cfg       in   21      nak interval register write
//
// one item per cycle while m_axis is not stalled; each accepted item gives exactly one
// result in the next cycle. the state update is a single pass of xmr_step between the
// control registers and the result register; s_axis_tready drops only while the result
// waits on a stalled m_axis. reset leaves no session open and nak interval at 2000000
// depends on xmr_pkg and xmr_step
`timescale 1ns / 1ps

module xmodem_receiver import xmr_pkg::*; #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]           s_axis_tuser,   // [1:0] op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] send_byte, [23:8] write_address, [31:24] write_data,
  // [33:32] status, [50:34] total_size, [55:51] zero
  output logic [55:0]          m_axis_tdata,
  // [0] send_valid, [1] write_valid
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [TICK_BITS-1:0] cfg_data_i
);

  xmr_ctl_t             ctl_q, ctl_d;
  logic [ADDR_BITS:0]   acc_q, acc_d;
  logic [TICK_BITS-1:0] nak_interval_q;
  xmr_result_t          res_q, res_d;
  logic                 out_valid_q;
  logic                 in_fire;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  xmr_step #(
    .ADDR_BITS(ADDR_BITS)
  ) u_step (
    .ctl_i         (ctl_q),
    .acc_i         (acc_q),
    .op_i          (xmr_op_e'(s_axis_tuser)),
    .byte_i        (s_axis_tdata),
    .nak_interval_i(nak_interval_q),
    .ctl_o         (ctl_d),
    .acc_o         (acc_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.phase      <= PH_IDLE;
      ctl_q.started    <= 1'b0;
      ctl_q.expected   <= 8'd1;
      ctl_q.header     <= 8'd0;
      ctl_q.idx        <= '0;
      ctl_q.sum        <= 8'd0;
      ctl_q.header_bad <= 1'b0;
      ctl_q.idle       <= '0;
      acc_q            <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (in_fire) begin
        ctl_q <= ctl_d;
        acc_q <= acc_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nak_interval_q <= NAK_INTERVAL_RST;
    end else if (cfg_valid_i) begin
      nak_interval_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, res_q.total_size, res_q.status, res_q.write_data,
                          res_q.write_address, res_q.send_byte};
  assign m_axis_tuser  = {res_q.write_valid, res_q.send_valid};
  assign m_axis_tlast  = res_q.finished;

  a_start_opens : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tuser == OP_START) |=> (ctl_q.phase == PH_CTRL && acc_q == '0))
    else $error("start did not open a fresh session");

  a_size_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tuser != OP_START) |=> (acc_q >= $past(acc_q)))
    else $error("accepted size went down within a session");

  a_one_action : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res_q.write_valid && res_q.send_valid))
    else $error("buffer write and reply in the same result");

  a_status_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res_q.finished) |-> (res_q.status == ST_OK))
    else $error("status set without session end");

  a_end_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_d.finished) |=> (ctl_q.phase == PH_IDLE))
    else $error("session end left the receiver active");

endmodule
